>>> rtl/median_filter_3x3_5x5_u8_assert.svh
// assertion helpers shared by mf35_fifo and mf35_back
`ifndef MEDIAN_FILTER_3X3_5X5_U8_ASSERT_SVH
`define MEDIAN_FILTER_3X3_5X5_U8_ASSERT_SVH

// same-cycle implication
`define MF35_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MF35_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mf35_pkg.sv
package mf35_pkg;

  localparam int RING_ROWS   = 5;
  localparam int SLOTS       = 5;
  localparam int WIN         = SLOTS * SLOTS;
  localparam int MED_RANK    = WIN / 2;
  localparam int MAX_RESULTS = 9;
  localparam int PX_W        = 12;
  localparam int CH_W        = 2;
  localparam int QDEPTH      = 4;
  localparam int QA_W        = $clog2(QDEPTH);
  localparam int QCNT_W      = QA_W + 1;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  typedef enum logic [2:0] {
    REG_KERNEL   = 3'd0,
    REG_WIDTH    = 3'd1,
    REG_CHANNELS = 3'd2,
    REG_HEIGHT   = 3'd3
  } reg_idx_t;

  typedef logic [SLOTS-1:0][7:0] col_t;

  typedef struct packed {
    logic            big;
    logic [PX_W-1:0] pix_last;
    logic [CH_W-1:0] ch_last;
  } geom_t;

  typedef struct packed {
    col_t            col;
    logic [CH_W-1:0] pch;
    logic [3:0]      nout;
    logic [PX_W-1:0] opx;
    logic [CH_W-1:0] och;
    logic            last_row;
  } job_t;

endpackage

>>> rtl/mf35_ram.sv
module mf35_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> rtl/mf35_front.sv
module mf35_front
  import mf35_pkg::*;
#(
  parameter int LINE_BYTES   = 4096,
  parameter int MAX_CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  logic [7:0]        in_sample,
  input  logic [QCNT_W-1:0] q_count,
  output logic              q_push,
  output job_t              q_data,
  output geom_t             geom
);

  localparam int AW = $clog2(LINE_BYTES);
  localparam int LW = $clog2(LINE_BYTES + 1);
  localparam int CAP1 = (LINE_BYTES > 4096) ? 4096 : LINE_BYTES;
  localparam int CAP2 = (LINE_BYTES / 2 > 4096) ? 4096 : LINE_BYTES / 2;
  localparam int CAP3 = (LINE_BYTES / 3 > 4096) ? 4096 : LINE_BYTES / 3;
  localparam int CAP4 = (LINE_BYTES / 4 > 4096) ? 4096 : LINE_BYTES / 4;

  function automatic logic [2:0] ring_back(input logic [2:0] b, input logic [2:0] d);
    logic [2:0] res;
    if (b >= d) begin
      res = b - d;
    end else begin
      res = 3'(4'(b) + 4'(RING_ROWS) - 4'(d));
    end
    return res;
  endfunction

  logic        kern_r;
  logic [12:0] width_r;
  logic [2:0]  chan_r;
  logic [12:0] height_r;

  logic [AW-1:0]   j_r, j_nxt, j_e;
  logic [CH_W-1:0] jc_r, jc_nxt, jc_e;
  logic [12:0]     i_r, i_nxt, i_e;
  logic [2:0]      ib_r, ib_nxt, ib_e;
  logic [AW-1:0]   oc_r, oc_nxt, oc_e;
  logic [PX_W-1:0] opx_r, opx_nxt, opx_e;
  logic [CH_W-1:0] och_r, och_nxt, och_e;

  logic [2:0]      ch_n;
  logic [12:0]     pix_sat, pix_cap, pix_n, h, h_r;
  logic [15:0]     len_w;
  logic [LW-1:0]   len, tgt, n_full;
  logic [1:0]      r;
  logic [3:0]      lag;
  logic [CH_W-1:0] ch_last;

  logic accept, flush, image, act, wr_en, has_out, line_end, orow_last, frame_done, restart;
  logic [3:0] nout;

  logic [SLOTS-1:0][2:0] bank;
  logic [SLOTS-1:0]      byp;

  logic                  a_valid_r;
  logic [SLOTS-1:0][2:0] a_bank_r;
  logic [SLOTS-1:0]      a_byp_r;
  logic [7:0]            a_smp_r;
  job_t                  a_job_r;
  logic [7:0]            rd [RING_ROWS];
  col_t                  colv;

  always_comb begin
    if (chan_r == 3'd0) begin
      ch_n = 3'd1;
    end else if (32'(chan_r) > MAX_CHANNELS) begin
      ch_n = 3'(MAX_CHANNELS);
    end else begin
      ch_n = chan_r;
    end
    if (width_r == 13'd0) begin
      pix_sat = 13'd1;
    end else if (width_r > 13'd4096) begin
      pix_sat = 13'd4096;
    end else begin
      pix_sat = width_r;
    end
    case (ch_n)
      3'd2:    pix_cap = 13'(CAP2);
      3'd3:    pix_cap = 13'(CAP3);
      3'd4:    pix_cap = 13'(CAP4);
      default: pix_cap = 13'(CAP1);
    endcase
    pix_n = (pix_sat > pix_cap) ? pix_cap : pix_sat;
    len_w = 16'(pix_n) * 16'(ch_n);
    len   = LW'(len_w);
    if (height_r == 13'd0) begin
      h = 13'd1;
    end else if (height_r > 13'd4096) begin
      h = 13'd4096;
    end else begin
      h = height_r;
    end
    r       = kern_r ? 2'd2 : 2'd1;
    lag     = kern_r ? {ch_n, 1'b0} : {1'b0, ch_n};
    h_r     = h + 13'(r);
    ch_last = CH_W'(ch_n - 3'd1);
  end

  assign geom.big      = kern_r;
  assign geom.pix_last = PX_W'(pix_n - 13'd1);
  assign geom.ch_last  = ch_last;

  assign in_stall = (QCNT_W'(q_count) + QCNT_W'(a_valid_r)) >= QCNT_W'(QDEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    restart = (i_r >= h_r) || (LW'(j_r) >= len);
    j_e   = restart ? '0 : j_r;
    jc_e  = restart ? '0 : jc_r;
    i_e   = restart ? '0 : i_r;
    ib_e  = restart ? '0 : ib_r;
    oc_e  = restart ? '0 : oc_r;
    opx_e = restart ? '0 : opx_r;
    och_e = restart ? '0 : och_r;

    flush     = (in_func == FUNC_FLUSH);
    image     = i_e < h;
    act       = accept && (image != flush);
    wr_en     = act && image;
    has_out   = i_e >= 13'(r);
    line_end  = LW'(j_e) == (len - LW'(1));
    orow_last = i_e == (h_r - 13'd1);
    frame_done = has_out && orow_last && line_end;

    if (!has_out) begin
      tgt = '0;
    end else if (line_end) begin
      tgt = len;
    end else if (LW'(j_e) >= LW'(lag)) begin
      tgt = LW'(j_e) - LW'(lag) + LW'(1);
    end else begin
      tgt = '0;
    end
    n_full = (tgt > LW'(oc_e)) ? tgt - LW'(oc_e) : '0;
    nout   = 4'(n_full);

    j_nxt   = j_e;
    jc_nxt  = jc_e;
    i_nxt   = i_e;
    ib_nxt  = ib_e;
    oc_nxt  = oc_e;
    opx_nxt = opx_e;
    och_nxt = och_e;
    if (act) begin
      if (line_end) begin
        j_nxt   = '0;
        jc_nxt  = '0;
        oc_nxt  = '0;
        opx_nxt = '0;
        och_nxt = '0;
        i_nxt   = i_e + 13'd1;
        ib_nxt  = (ib_e == 3'(RING_ROWS - 1)) ? 3'd0 : ib_e + 3'd1;
        if (frame_done || (i_e + 13'd1) >= h_r) begin
          i_nxt  = '0;
          ib_nxt = '0;
        end
      end else begin
        j_nxt  = j_e + AW'(1);
        jc_nxt = (jc_e == ch_last) ? '0 : jc_e + CH_W'(1);
        if (nout != 4'd0) begin
          oc_nxt = oc_e + AW'(1);
          if (och_e == ch_last) begin
            och_nxt = '0;
            opx_nxt = opx_e + PX_W'(1);
          end else begin
            och_nxt = och_e + CH_W'(1);
          end
        end
      end
    end
  end

  // row bank for each window row, with top and bottom edge repeat
  always_comb begin
    int dd_i;
    logic [2:0] dd;
    dd_i = 0;
    dd   = '0;
    for (int s = 0; s < SLOTS; s++) begin
      dd_i = int'(r) + 2 - s;
      if (!kern_r && (s == 0 || s == SLOTS - 1)) begin
        dd_i = 0;
      end
      dd = 3'(dd_i);
      byp[s] = 1'b0;
      if (13'(dd) > i_e) begin
        bank[s] = 3'd0;
      end else if ((i_e - 13'(dd)) >= h) begin
        bank[s] = ring_back(ib_e, 3'(i_e - h + 13'd1));
      end else begin
        bank[s] = ring_back(ib_e, dd);
        byp[s]  = (dd == 3'd0);
      end
    end
  end

  for (genvar g = 0; g < RING_ROWS; g++) begin : g_bank
    mf35_ram #(
      .WIDTH(8),
      .DEPTH(LINE_BYTES)
    ) u_ram (
      .clk  (clk),
      .we   (wr_en && (ib_e == 3'(g))),
      .waddr(j_e),
      .wdata(in_sample),
      .raddr(j_e),
      .rdata(rd[g])
    );
  end

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      colv[s] = a_byp_r[s] ? a_smp_r : rd[a_bank_r[s]];
    end
    q_data     = a_job_r;
    q_data.col = colv;
  end

  assign q_push = a_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_r    <= 1'b0;
      width_r   <= 13'd640;
      chan_r    <= 3'd1;
      height_r  <= 13'd480;
      j_r       <= '0;
      jc_r      <= '0;
      i_r       <= '0;
      ib_r      <= '0;
      oc_r      <= '0;
      opx_r     <= '0;
      och_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= act && has_out;
      if (cfg_we && (cfg_index == REG_KERNEL || cfg_index == REG_WIDTH ||
                     cfg_index == REG_CHANNELS || cfg_index == REG_HEIGHT)) begin
        case (reg_idx_t'(cfg_index))
          REG_KERNEL:   kern_r   <= cfg_data[0];
          REG_WIDTH:    width_r  <= cfg_data;
          REG_CHANNELS: chan_r   <= cfg_data[2:0];
          REG_HEIGHT:   height_r <= cfg_data;
          default:      kern_r   <= kern_r;
        endcase
        j_r   <= '0;
        jc_r  <= '0;
        i_r   <= '0;
        ib_r  <= '0;
        oc_r  <= '0;
        opx_r <= '0;
        och_r <= '0;
      end else if (accept) begin
        j_r   <= j_nxt;
        jc_r  <= jc_nxt;
        i_r   <= i_nxt;
        ib_r  <= ib_nxt;
        oc_r  <= oc_nxt;
        opx_r <= opx_nxt;
        och_r <= och_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_bank_r         <= bank;
    a_byp_r          <= byp;
    a_smp_r          <= in_sample;
    a_job_r.col      <= '0;
    a_job_r.pch      <= jc_e;
    a_job_r.nout     <= nout;
    a_job_r.opx      <= opx_e;
    a_job_r.och      <= och_e;
    a_job_r.last_row <= orow_last;
  end

endmodule

>>> rtl/mf35_fifo.sv
`include "median_filter_3x3_5x5_u8_assert.svh"

module mf35_fifo
  import mf35_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  job_t              push_data,
  input  logic              pop,
  output job_t              head,
  output logic [QCNT_W-1:0] count,
  output logic              empty
);

  job_t              mem_r [QDEPTH];
  logic [QA_W-1:0]   wr_r, rd_r;
  logic [QCNT_W-1:0] count_r;

  assign head  = mem_r[rd_r];
  assign count = count_r;
  assign empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QA_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QA_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  `MF35_CHECK(a_no_overflow, push, (count_r < QCNT_W'(QDEPTH)) || pop, "request queue overflow")
  `MF35_CHECK_NEXT(a_pop_drains, pop && !push, count_r == $past(count_r) - QCNT_W'(1), "bad level")

endmodule

>>> rtl/mf35_back.sv
`include "median_filter_3x3_5x5_u8_assert.svh"

module mf35_back
  import mf35_pkg::*;
#(
  parameter int MAX_CHANNELS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       e,
  input  logic       q_empty,
  output logic       q_pop,
  input  geom_t      geom,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_median,
  output logic       out_end_of_run,
  output logic       out_end_of_frame
);

  logic            move, issue, last_job, has_job, push;
  logic [3:0]      sub_r;
  logic [PX_W-1:0] px_r, job_px, px_inc;
  logic [CH_W-1:0] c_r, job_c, c_inc;

  col_t hist_r [MAX_CHANNELS][SLOTS];
  col_t view [SLOTS];

  logic [SLOTS-1:0][2:0] kidx;
  logic [WIN-1:0][7:0]   win;
  logic                  job_eof;

  logic                          v1_r, v2_r, v3_r, out_valid_r;
  logic                          eor1_r, eor2_r, eor3_r, eof1_r, eof2_r, eof3_r;
  logic [WIN-1:0][7:0]           w1_r, w2_r, w3_r;
  logic [WIN-1:0][WIN-1:0]       b2_r;
  logic [WIN-1:0][4:0]           rank3_r;
  logic [WIN-1:0]                match;
  logic [7:0]                    med;
  logic [7:0]                    med_r;
  logic                          eor_r, eof_r;

  assign move     = !out_valid_r || !out_stall;
  assign issue    = move && !q_empty;
  assign last_job = (e.nout == 4'd0) || (sub_r == e.nout - 4'd1);
  assign q_pop    = issue && last_job;
  assign has_job  = issue && (e.nout != 4'd0);
  assign push     = issue && (sub_r == 4'd0);
  assign job_px   = (sub_r == 4'd0) ? e.opx : px_r;
  assign job_c    = (sub_r == 4'd0) ? e.och : c_r;
  assign c_inc    = (job_c == geom.ch_last) ? '0 : job_c + CH_W'(1);
  assign px_inc   = (job_c == geom.ch_last) ? job_px + PX_W'(1) : job_px;
  assign job_eof  = e.last_row && (job_px == geom.pix_last) && (job_c == geom.ch_last);

  // channel columns, newest first, with this request's column shifted in
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      view[k] = '0;
    end
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      if (job_c == CH_W'(ch)) begin
        if (push && (e.pch == CH_W'(ch))) begin
          view[0] = e.col;
          for (int k = 1; k < SLOTS; k++) begin
            view[k] = hist_r[ch][k-1];
          end
        end else begin
          for (int k = 0; k < SLOTS; k++) begin
            view[k] = hist_r[ch][k];
          end
        end
      end
    end
  end

  // column tap per window column, with left and right edge repeat
  always_comb begin
    int nc;
    int t;
    nc = int'(job_px) + (geom.big ? 2 : 1);
    if (nc > int'(geom.pix_last)) begin
      nc = int'(geom.pix_last);
    end
    t = 0;
    for (int x = 0; x < SLOTS; x++) begin
      t = int'(job_px) + x - 2;
      if (t < 0) begin
        t = 0;
      end
      if (t > int'(geom.pix_last)) begin
        t = int'(geom.pix_last);
      end
      kidx[x] = 3'(nc - t);
    end
  end

  // 3x3 sits in the middle, ring padded with equal counts of 0 and 255
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      for (int x = 0; x < SLOTS; x++) begin
        if (!geom.big && (s == 0 || s == SLOTS - 1 || x == 0 || x == SLOTS - 1)) begin
          win[s*SLOTS+x] = ((s * SLOTS + x) < MED_RANK) ? 8'h00 : 8'hFF;
        end else begin
          win[s*SLOTS+x] = view[kidx[x]][s];
        end
      end
    end
  end

  always_comb begin
    med = '0;
    for (int a = 0; a < WIN; a++) begin
      match[a] = (rank3_r[a] == 5'(MED_RANK));
      if (match[a]) begin
        med = w3_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        sub_r <= last_job ? 4'd0 : sub_r + 4'd1;
      end
      if (move) begin
        v1_r        <= has_job;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      px_r <= px_inc;
      c_r  <= c_inc;
    end
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      if (push && (e.pch == CH_W'(ch))) begin
        hist_r[ch][0] <= e.col;
        for (int k = 1; k < SLOTS; k++) begin
          hist_r[ch][k] <= hist_r[ch][k-1];
        end
      end
    end
    if (move) begin
      w1_r   <= win;
      eor1_r <= last_job;
      eof1_r <= job_eof;
      for (int a = 0; a < WIN; a++) begin
        for (int b = 0; b < WIN; b++) begin
          b2_r[a][b] <= (w1_r[b] < w1_r[a]) || ((w1_r[b] == w1_r[a]) && (b < a));
        end
      end
      w2_r   <= w1_r;
      eor2_r <= eor1_r;
      eof2_r <= eof1_r;
      for (int a = 0; a < WIN; a++) begin
        rank3_r[a] <= 5'($countones(b2_r[a]));
      end
      w3_r   <= w2_r;
      eor3_r <= eor2_r;
      eof3_r <= eof2_r;
      med_r  <= med;
      eor_r  <= eor3_r;
      eof_r  <= eof3_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median       = med_r;
  assign out_end_of_run   = eor_r;
  assign out_end_of_frame = eof_r;

  `MF35_CHECK(a_pop_nonempty, q_pop, !q_empty, "pop from empty queue")
  `MF35_CHECK(a_burst_len, issue, e.nout <= 4'(MAX_RESULTS), "too many results for one request")
  `MF35_CHECK(a_rank_unique, v3_r, $onehot(match), "median rank not unique")

endmodule

>>> rtl/median_filter_3x3_5x5_u8.sv
// channel | direction | ports
// in      | in        | in_valid, in_stall, in_func, in_sample
// out     | out       | out_valid, out_stall, out_median, out_end_of_run, out_end_of_frame
// cfg     | in        | cfg_we, cfg_index, cfg_data
//
// one request per clock unless in_stall is high; a request gives at most one result, but a row end
// gives up to radius*channels+1 results, which the single median unit produces one at a time
// each result passes the line store read, the queue, then 4 median stages
// reset is synchronous; line store has no clearing pass and needs no warm-up
// a stalled output holds the whole median pipeline; the input stalls only when the queue fills
module median_filter_3x3_5x5_u8
  import mf35_pkg::*;
#(
  parameter int LINE_BYTES   = 4096,
  parameter int MAX_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_median,
  output logic        out_end_of_run,
  output logic        out_end_of_frame
);

  logic              q_push, q_pop, q_empty;
  job_t              q_data, q_head;
  logic [QCNT_W-1:0] q_count;
  geom_t             geom;

  mf35_front #(
    .LINE_BYTES  (LINE_BYTES),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_func),
    .in_sample(in_sample),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_data   (q_data),
    .geom     (geom)
  );

  mf35_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_data),
    .pop      (q_pop),
    .head     (q_head),
    .count    (q_count),
    .empty    (q_empty)
  );

  mf35_back #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .e               (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .geom            (geom),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_median      (out_median),
    .out_end_of_run  (out_end_of_run),
    .out_end_of_frame(out_end_of_frame)
  );

endmodule

>>> dv/tb_top.sv
module tb_top;
  import mf35_pkg::*;

  localparam int STORE_ROW = 4096;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [7:0] median;
    logic       eor;
    logic       eof;
  } median_res_t;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    idx;
    logic [12:0] val;
    logic        func;
    logic [7:0]  sample;
    bit          quiet;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [7:0]  in_sample;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_median;
  logic        out_end_of_run;
  logic        out_end_of_frame;

  median_filter_3x3_5x5_u8 u_dut (.*);

  // predictor state
  logic [7:0]  row_ring [0:RING_ROWS*STORE_ROW-1];
  int unsigned in_col, in_row, out_col;
  int unsigned m_kernel, m_width, m_chans, m_height;
  median_res_t medians_q[$];

  int  errors;
  int  n_req, n_res, n_frames, n_ignored, n_exp;
  bit  idle_en;
  bit  hold_req;
  int  quiet_cnt;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic logic [7:0] window_mid(int unsigned orow, int unsigned oc, int r,
                                            int unsigned chn, int unsigned pixn,
                                            int unsigned h);
    logic [7:0] vals[$];
    int px, ch, rw, cx;
    px = oc / chn;
    ch = oc % chn;
    for (int dy = -r; dy <= r; dy++) begin
      rw = clampi(int'(orow) + dy, 0, int'(h) - 1);
      for (int dx = -r; dx <= r; dx++) begin
        cx = clampi(px + dx, 0, int'(pixn) - 1);
        vals.push_back(row_ring[(rw % RING_ROWS) * STORE_ROW + cx * chn + ch]);
      end
    end
    vals.sort();
    return vals[vals.size() / 2];
  endfunction

  function automatic void filter_cfg(reg_idx_t idx, logic [12:0] v);
    case (idx)
      REG_KERNEL:   m_kernel = v[0];
      REG_WIDTH:    m_width  = v;
      REG_CHANNELS: m_chans  = v[2:0];
      REG_HEIGHT:   m_height = v;
      default: ;
    endcase
    in_col = 0;
    in_row = 0;
    out_col = 0;
  endfunction

  function automatic void filter_item(logic f, logic [7:0] s);
    int unsigned chn, pixn, h, r, len, lag, j, i, tgt, orow, n;
    bit done;
    median_res_t m;
    chn  = sat(m_chans, 1, 4);
    pixn = sat(m_width, 1, 4096);
    h    = sat(m_height, 1, 4096);
    r    = m_kernel ? 2 : 1;
    if (pixn > STORE_ROW / chn) pixn = STORE_ROW / chn;
    len = pixn * chn;
    lag = r * chn;
    done = 0;
    n = 0;
    if (in_row >= h + r || in_col >= len) begin
      in_row = 0;
      in_col = 0;
      out_col = 0;
    end
    j = in_col;
    i = in_row;
    if ((i < h) == (f == FUNC_FLUSH)) begin
      n_ignored++;
      return;
    end
    if (i < h) row_ring[(i % RING_ROWS) * STORE_ROW + j] = s;
    if (i >= r) begin
      orow = i - r;
      if (j == len - 1) tgt = len;
      else tgt = (j >= lag) ? j - lag + 1 : 0;
      while (out_col < tgt && n < MAX_RESULTS) begin
        m.median = window_mid(orow, out_col, r, chn, pixn, h);
        m.eor = 1'b0;
        m.eof = (orow == h - 1 && out_col == len - 1);
        if (m.eof) done = 1;
        medians_q.push_back(m);
        n_exp++;
        out_col++;
        n++;
      end
      if (n > 0) medians_q[medians_q.size() - 1].eor = 1'b1;
    end
    j++;
    if (j >= len) begin
      j = 0;
      out_col = 0;
      i++;
      if (done || i >= h + r) i = 0;
    end
    in_col = j;
    in_row = i;
  endfunction

  task automatic send(logic f, logic [7:0] s);
    while (idle_en && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= f;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    filter_item(f, s);
    n_req++;
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [12:0] v);
    in_valid <= 1'b0;
    wait (medians_q.size() == 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    filter_cfg(idx, v);
  endtask

  task automatic set_geometry(int k, int w, int ch, int h);
    write_reg(REG_KERNEL, 13'(k));
    write_reg(REG_WIDTH, 13'(w));
    write_reg(REG_CHANNELS, 13'(ch));
    write_reg(REG_HEIGHT, 13'(h));
  endtask

  function automatic logic [7:0] rand_sample();
    return ($urandom_range(3) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom);
  endfunction

  // one frame plus flush rows; noise items come in the wrong phase, a nonzero cap drops the tail
  task automatic send_frame(int k, int w, int ch, int h, int noise, int cap);
    int len, rows, stop;
    len  = w * ch;
    rows = h + (k ? 2 : 1);
    stop = rows * len;
    if (cap > 0 && cap < stop) stop = cap;
    for (int p = 0; p < stop; p++) begin
      if ($urandom_range(99) < noise)
        send((p / len) < h ? FUNC_FLUSH : FUNC_SAMPLE, rand_sample());
      send((p / len) < h ? FUNC_SAMPLE : FUNC_FLUSH, rand_sample());
    end
    if (stop == rows * len) n_frames++;
  endtask

  stim_row_t dir_tab[] = '{
    '{1, REG_KERNEL,   13'd0, 0, 0, 0},
    '{1, REG_WIDTH,    13'd2, 0, 0, 0},
    '{1, REG_CHANNELS, 13'd1, 0, 0, 0},
    '{1, REG_HEIGHT,   13'd2, 0, 0, 0},
    '{0, REG_KERNEL,   13'd0, FUNC_FLUSH,  8'hAA, 1},
    '{0, REG_KERNEL,   13'd0, FUNC_SAMPLE, 8'hFF, 1},
    '{0, REG_KERNEL,   13'd0, FUNC_SAMPLE, 8'h00, 1},
    '{0, REG_KERNEL,   13'd0, FUNC_SAMPLE, 8'h00, 0},
    '{0, REG_KERNEL,   13'd0, FUNC_SAMPLE, 8'hFF, 0},
    '{0, REG_KERNEL,   13'd0, FUNC_SAMPLE, 8'h55, 1},
    '{0, REG_KERNEL,   13'd0, FUNC_FLUSH,  8'h00, 0},
    '{0, REG_KERNEL,   13'd0, FUNC_FLUSH,  8'hFF, 0},
    '{1, REG_KERNEL,   13'd1, 0, 0, 0},
    '{1, REG_WIDTH,    13'd0, 0, 0, 0},
    '{1, REG_CHANNELS, 13'd0, 0, 0, 0},
    '{1, REG_HEIGHT,   13'd0, 0, 0, 0},
    '{0, REG_KERNEL,   13'd0, FUNC_SAMPLE, 8'h80, 1},
    '{0, REG_KERNEL,   13'd0, FUNC_FLUSH,  8'h7F, 0},
    '{0, REG_KERNEL,   13'd0, FUNC_FLUSH,  8'h01, 0}
  };

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_res++;
      if (medians_q.size() == 0) begin
        $display("%0t: unexpected result median=%0d", $time, out_median);
        errors++;
      end else begin
        if (out_median !== medians_q[0].median || out_end_of_run !== medians_q[0].eor ||
            out_end_of_frame !== medians_q[0].eof) begin
          $display("%0t: expected median=%0d eor=%0b eof=%0b, got median=%0d eor=%0b eof=%0b",
                   $time, medians_q[0].median, medians_q[0].eor, medians_q[0].eof,
                   out_median, out_end_of_run, out_end_of_frame);
          errors++;
        end
        void'(medians_q.pop_front());
      end
    end
  end

  // receiver stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        for (int c = 0; c < HOLD_CYCLES; c++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
        hold_req = 0;
      end
      out_stall <= idle_en && ($urandom_range(99) < 15);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int k, w, ch, h, qlen, rand_start, cap;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_func = FUNC_SAMPLE; in_sample = '0;
    errors = 0; n_req = 0; n_res = 0; n_frames = 0; n_ignored = 0; n_exp = 0;
    idle_en = 1; hold_req = 0;
    m_kernel = 0; m_width = 640; m_chans = 1; m_height = 480;
    in_col = 0; in_row = 0; out_col = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[t]) begin
      if (dir_tab[t].is_cfg) write_reg(dir_tab[t].idx, dir_tab[t].val);
      else begin
        qlen = n_exp;
        send(dir_tab[t].func, dir_tab[t].sample);
        if (dir_tab[t].quiet && n_exp != qlen) begin
          $display("%0t: request expected to give no result, got %0d", $time,
                   n_exp - qlen);
          errors++;
        end
      end
    end

    // widest row, most channels
    set_geometry(0, 4096, 4, 1);
    send_frame(0, 1024, 4, 1, 2, 40);
    // tallest frame, width and channels saturated
    set_geometry(1, 8191, 7, 4096);
    send_frame(1, 1024, 4, 4096, 0, 30);
    set_geometry(1, 1, 1, 4096);
    send_frame(1, 1, 1, 4096, 0, 40);

    rand_start = n_req;
    for (int ph = 0; n_req - rand_start < 330; ph++) begin
      k  = $urandom_range(1);
      w  = $urandom_range(1, 6);
      ch = $urandom_range(1, 4);
      h  = $urandom_range(1, 5);
      if (ph == 1) begin
        w  = 6;
        ch = 4;
        h  = 5;
      end
      set_geometry(k, w, ch, h);
      idle_en = (ph != 0);
      if (ph == 1) hold_req = 1;
      send_frame(k, w, ch, h, 8, 0);
      if (ph == 2) begin
        in_valid <= 1'b0;
        wait (medians_q.size() == 0);
        @(negedge clk);
      end
      cap = ($urandom_range(3) == 0) ? int'($urandom_range((h + 1 + k) * w * ch)) : 0;
      send_frame(k, w, ch, h, 8, cap);
    end
    idle_en = 1;
    in_valid <= 1'b0;

    wait (medians_q.size() == 0);
    repeat (40) @(posedge clk);
    if (medians_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, medians_q.size());
      errors++;
    end
    $display("covered %0d requests (%0d ignored by phase), %0d results, %0d full frames",
             n_req, n_ignored, n_res, n_frames);
    $display("3x3 and 5x5 windows, 1 to 4 channels, widths up to 4096, heights up to 4096");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mf35_pkg.sv
rtl/mf35_ram.sv
rtl/mf35_front.sv
rtl/mf35_fifo.sv
rtl/mf35_back.sv
rtl/median_filter_3x3_5x5_u8.sv
dv/tb_top.sv
